FILE: hdl/pit_pkg.sv
// pit_pkg: widths, shape codes and shared types for the point-in-triangle test
// no dependencies; imported by pit_cross, point_in_triangle_test and tb
package pit_pkg;

	// coordinate and arithmetic widths
	localparam int COORD_WIDTH = 16;
	localparam int DIFF_W      = COORD_WIDTH + 1;
	localparam int PROD_W      = 2 * DIFF_W;
	localparam int CROSS_W     = PROD_W + 1;

	// shape case reported with each result
	typedef enum logic [1:0] {
		SHAPE_TRI = 2'd0,
		SHAPE_SEG = 2'd1,
		SHAPE_PT  = 2'd2
	} shape_t;

	// sign of a doubled area
	typedef struct packed {
		logic zero;
		logic neg;
	} pit_sign_t;

	// stage advance enables handed to the cross-product lanes
	typedef struct packed {
		logic s2;
		logic s3;
	} pit_adv_t;

endpackage

FILE: hdl/point_in_triangle_test.sv
// point_in_triangle_test: four-stage pipeline from accepted beat to result
// throughput one beat per cycle while the result is not stalled; a stalled result holds and earlier stages keep filling
// the four doubled-area lanes (eight 17x17 multipliers) set the stage-2 and stage-3 depth
// reset clears the stage valid bits only; payload registers are not reset
// depends on pit_pkg and pit_cross
module point_in_triangle_test import pit_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic signed [COORD_WIDTH-1:0] ax,
	input  logic signed [COORD_WIDTH-1:0] ay,
	input  logic signed [COORD_WIDTH-1:0] bx,
	input  logic signed [COORD_WIDTH-1:0] by_coord,
	input  logic signed [COORD_WIDTH-1:0] cx,
	input  logic signed [COORD_WIDTH-1:0] cy,
	input  logic signed [COORD_WIDTH-1:0] px,
	input  logic signed [COORD_WIDTH-1:0] py,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic                          inside_res,
	output logic [1:0]                    shape_kind
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;
	pit_adv_t adv;

	// stage 1 payload
	logic signed [DIFF_W-1:0] bax_s1, bay_s1, cax_s1, cay_s1;
	logic signed [DIFF_W-1:0] cbx_s1, cby_s1, pbx_s1, pby_s1;
	logic signed [DIFF_W-1:0] acx_s1, acy_s1, pcx_s1, pcy_s1;
	logic signed [DIFF_W-1:0] eax_s1, eay_s1, pax_s1, pay_s1;
	logic all_same_s1, p_eq_a_s1, in_box_s1;
	logic all_same_s2, p_eq_a_s2, in_box_s2;
	logic all_same_s3, p_eq_a_s3, in_box_s3;

	// stage 1 combinational terms
	logic signed [DIFF_W-1:0] axe, aye, bxe, bye, cxe, cye, pxe, pye, exe, eye;
	logic ab_same;

	pit_sign_t tot_s3, s1_s3, s2_s3, s3_s3;
	logic   inside_s4;
	shape_t kind_s4;
	logic   in_tri;
	logic   in_seg;

	// advance chain: a stage moves when it is empty or its successor moves
	assign en4 = !v_s4 || !res_stall;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign item_stall = !en1;
	assign adv.s2 = en2;
	assign adv.s3 = en3;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= item_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// sign-extended coordinates
	assign axe = $signed({ax[COORD_WIDTH-1], ax});
	assign aye = $signed({ay[COORD_WIDTH-1], ay});
	assign bxe = $signed({bx[COORD_WIDTH-1], bx});
	assign bye = $signed({by_coord[COORD_WIDTH-1], by_coord});
	assign cxe = $signed({cx[COORD_WIDTH-1], cx});
	assign cye = $signed({cy[COORD_WIDTH-1], cy});
	assign pxe = $signed({px[COORD_WIDTH-1], px});
	assign pye = $signed({py[COORD_WIDTH-1], py});

	// segment direction: b, or c when a and b coincide
	assign ab_same = (ax == bx) && (ay == by_coord);
	assign exe = ab_same ? cxe : bxe;
	assign eye = ab_same ? cye : bye;

	// stage 1: edge differences and the equality and bounding-box flags
	always_ff @(posedge clk) begin
		if (en1) begin
			bax_s1 <= bxe - axe;
			bay_s1 <= bye - aye;
			cax_s1 <= cxe - axe;
			cay_s1 <= cye - aye;
			cbx_s1 <= cxe - bxe;
			cby_s1 <= cye - bye;
			pbx_s1 <= pxe - bxe;
			pby_s1 <= pye - bye;
			acx_s1 <= axe - cxe;
			acy_s1 <= aye - cye;
			pcx_s1 <= pxe - cxe;
			pcy_s1 <= pye - cye;
			eax_s1 <= exe - axe;
			eay_s1 <= eye - aye;
			pax_s1 <= pxe - axe;
			pay_s1 <= pye - aye;
			all_same_s1 <= ab_same && (bx == cx) && (by_coord == cy);
			p_eq_a_s1   <= (px == ax) && (py == ay);
			in_box_s1   <= (px >= ax || px >= bx || px >= cx)
				&& (px <= ax || px <= bx || px <= cx)
				&& (py >= ay || py >= by_coord || py >= cy)
				&& (py <= ay || py <= by_coord || py <= cy);
		end
	end

	// flags ride alongside the lanes
	always_ff @(posedge clk) begin
		if (en2) begin
			all_same_s2 <= all_same_s1;
			p_eq_a_s2   <= p_eq_a_s1;
			in_box_s2   <= in_box_s1;
		end
		if (en3) begin
			all_same_s3 <= all_same_s2;
			p_eq_a_s3   <= p_eq_a_s2;
			in_box_s3   <= in_box_s2;
		end
	end

	// total area (a, b, c)
	pit_cross u_tot (
		.clk(clk), .adv(adv),
		.m0a(bax_s1), .m0b(cay_s1), .m1a(bay_s1), .m1b(cax_s1),
		.sign_s3(tot_s3)
	);

	// sub-area (b, c, p)
	pit_cross u_sub1 (
		.clk(clk), .adv(adv),
		.m0a(cbx_s1), .m0b(pby_s1), .m1a(cby_s1), .m1b(pbx_s1),
		.sign_s3(s1_s3)
	);

	// sub-area (c, a, p)
	pit_cross u_sub2 (
		.clk(clk), .adv(adv),
		.m0a(acx_s1), .m0b(pcy_s1), .m1a(acy_s1), .m1b(pcx_s1),
		.sign_s3(s2_s3)
	);

	// sub-area (a, e, p): (a, b, p) for a triangle, collinearity for a segment
	pit_cross u_sub3 (
		.clk(clk), .adv(adv),
		.m0a(eax_s1), .m0b(pay_s1), .m1a(eay_s1), .m1b(pax_s1),
		.sign_s3(s3_s3)
	);

	// decision terms for the triangle and segment cases
	assign in_tri = (s1_s3.zero || (s1_s3.neg == tot_s3.neg))
		&& (s2_s3.zero || (s2_s3.neg == tot_s3.neg))
		&& (s3_s3.zero || (s3_s3.neg == tot_s3.neg));
	assign in_seg = s3_s3.zero && in_box_s3;

	// stage 4: result register
	always_ff @(posedge clk) begin
		if (en4) begin
			if (all_same_s3) begin
				kind_s4   <= SHAPE_PT;
				inside_s4 <= p_eq_a_s3;
			end else if (tot_s3.zero) begin
				kind_s4   <= SHAPE_SEG;
				inside_s4 <= in_seg;
			end else begin
				kind_s4   <= SHAPE_TRI;
				inside_s4 <= in_tri;
			end
		end
	end

	assign res_valid  = v_s4;
	assign inside_res = inside_s4;
	assign shape_kind = kind_s4;

	// result beats only carry defined shape codes
	a_kind_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (shape_kind == SHAPE_TRI || shape_kind == SHAPE_SEG
			|| shape_kind == SHAPE_PT))
		else $error("undefined shape code on a result beat");

	// a free output means the whole pipeline advances
	a_no_stall_free: assert property (@(posedge clk) disable iff (!arst_n)
		!res_stall |-> !item_stall)
		else $error("input stalled while the output is free");

	// input stalls only when every stage is full and the output is held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && res_stall))
		else $error("input stalled with room in the pipeline");

endmodule

FILE: hdl/pit_cross.sv
// pit_cross: one doubled-area lane, two products in stage 2, difference and sign in stage 3
// depends on pit_pkg
module pit_cross import pit_pkg::*; (
	input  logic                     clk,
	input  pit_adv_t                 adv,
	input  logic signed [DIFF_W-1:0] m0a,
	input  logic signed [DIFF_W-1:0] m0b,
	input  logic signed [DIFF_W-1:0] m1a,
	input  logic signed [DIFF_W-1:0] m1b,
	output pit_sign_t                sign_s3
);

	logic signed [PROD_W-1:0]  p0_s2;
	logic signed [PROD_W-1:0]  p1_s2;
	logic signed [CROSS_W-1:0] area_diff;

	// products at full width
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			p0_s2 <= m0a * m0b;
			p1_s2 <= m1a * m1b;
		end
	end

	// difference of the products
	assign area_diff = $signed({p0_s2[PROD_W-1], p0_s2}) - $signed({p1_s2[PROD_W-1], p1_s2});

	// keep only the sign of the area
	always_ff @(posedge clk) begin
		if (adv.s3) begin
			sign_s3.zero <= (area_diff == '0);
			sign_s3.neg  <= area_diff[CROSS_W-1];
		end
	end

endmodule

FILE: verif/tb.sv
// tb: self-checking bench for point_in_triangle_test, random and directed queries
// a queue-fed driver and a monitor compare each result beat with a local containment predictor
// depends on pit_pkg and the point_in_triangle_test rtl
module tb;
	import pit_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 8;
	localparam int RANDOM_ITEMS = 650;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int IDLE_PCT     = 11;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		coord_t ax, ay, bx, by_coord, cx, cy, px, py;
	} tri_query_t;

	typedef struct {
		logic   hit;
		shape_t shape;
	} verdict_t;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       item_valid = 1'b0;
	logic       res_stall  = 1'b0;
	tri_query_t in_beat    = '0;
	logic       item_stall;
	logic       res_valid;
	logic       inside_res;
	logic [1:0] shape_kind;

	tri_query_t pending_queries[$];
	verdict_t   expected_verdicts[$];
	int         sent_cnt, got_cnt, err_cnt;
	int         tri_cnt, seg_cnt, pt_cnt, inside_cnt;
	int         quiet_cycles;

	point_in_triangle_test dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.ax         (in_beat.ax),
		.ay         (in_beat.ay),
		.bx         (in_beat.bx),
		.by_coord   (in_beat.by_coord),
		.cx         (in_beat.cx),
		.cy         (in_beat.cy),
		.px         (in_beat.px),
		.py         (in_beat.py),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.inside_res (inside_res),
		.shape_kind (shape_kind)
	);

	// clock
	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// doubled signed area of (u, v, w)
	function automatic longint area2(longint ux, longint uy, longint vx, longint vy,
			longint wx, longint wy);
		return (vx - ux) * (wy - uy) - (vy - uy) * (wx - ux);
	endfunction

	function automatic int sign_of(longint v);
		if (v > 0) return 1;
		if (v < 0) return -1;
		return 0;
	endfunction

	function automatic longint min3(longint a, longint b, longint c);
		longint m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic longint max3(longint a, longint b, longint c);
		longint m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	// containment predictor: point, segment or proper triangle case
	function automatic verdict_t judge_query(tri_query_t q);
		longint   ax, ay, bx, by, cx, cy, px, py, total, ex, ey;
		int       s, s1, s2, s3;
		logic     ab_same;
		verdict_t v;
		ax = $signed(q.ax);
		ay = $signed(q.ay);
		bx = $signed(q.bx);
		by = $signed(q.by_coord);
		cx = $signed(q.cx);
		cy = $signed(q.cy);
		px = $signed(q.px);
		py = $signed(q.py);
		ab_same = (ax == bx) && (ay == by);
		if (ab_same && bx == cx && by == cy) begin
			v.shape = SHAPE_PT;
			v.hit   = (px == ax) && (py == ay);
		end else begin
			total = area2(ax, ay, bx, by, cx, cy);
			if (total == 0) begin
				// collinear line taken through a and b, or a and c when a equals b
				ex = ab_same ? cx : bx;
				ey = ab_same ? cy : by;
				v.shape = SHAPE_SEG;
				v.hit   = area2(ax, ay, ex, ey, px, py) == 0
					&& px >= min3(ax, bx, cx) && px <= max3(ax, bx, cx)
					&& py >= min3(ay, by, cy) && py <= max3(ay, by, cy);
			end else begin
				s  = sign_of(total);
				s1 = sign_of(area2(bx, by, cx, cy, px, py));
				s2 = sign_of(area2(cx, cy, ax, ay, px, py));
				s3 = sign_of(area2(ax, ay, bx, by, px, py));
				v.shape = SHAPE_TRI;
				v.hit   = (s1 == 0 || s1 == s) && (s2 == 0 || s2 == s)
					&& (s3 == 0 || s3 == s);
			end
		end
		return v;
	endfunction

	// uniform coordinate in [-lim, lim-1]
	function automatic longint pick_coord(int lim);
		longint r;
		r = longint'($urandom_range(0, 2 * lim - 1));
		return r - lim;
	endfunction

	function automatic tri_query_t mk_query(longint ax, longint ay, longint bx, longint by,
			longint cx, longint cy, longint px, longint py);
		tri_query_t q;
		q.ax       = coord_t'(ax);
		q.ay       = coord_t'(ay);
		q.bx       = coord_t'(bx);
		q.by_coord = coord_t'(by);
		q.cx       = coord_t'(cx);
		q.cy       = coord_t'(cy);
		q.px       = coord_t'(px);
		q.py       = coord_t'(py);
		return q;
	endfunction

	// input driver: holds a stalled beat, idles at random outside a quiet window
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			in_beat    <= '0;
		end else begin
			if (item_valid && !item_stall) begin
				expected_verdicts.push_back(judge_query(in_beat));
				sent_cnt++;
			end
			if (!item_valid || !item_stall) begin
				if (pending_queries.size() != 0 && ((sent_cnt >= 250 && sent_cnt < 400)
						|| $urandom_range(0, 99) >= IDLE_PCT)) begin
					in_beat    <= pending_queries.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: compare each accepted beat with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				got_cnt++;
				if (expected_verdicts.size() == 0) begin
					$error("result beat with no expectation waiting");
					err_cnt++;
				end else begin
					want = expected_verdicts.pop_front();
					case (want.shape)
						SHAPE_TRI: tri_cnt++;
						SHAPE_SEG: seg_cnt++;
						default:   pt_cnt++;
					endcase
					if (want.hit) inside_cnt++;
					if (inside_res !== want.hit) begin
						$error("inside_res: expected %0d, actual %0d", want.hit, inside_res);
						err_cnt++;
					end
					if (shape_kind !== want.shape) begin
						$error("shape_kind: expected %0d, actual %0d", want.shape, shape_kind);
						err_cnt++;
					end
				end
			end
			res_stall <= !(got_cnt >= 320 && got_cnt < 470) && $urandom_range(0, 99) < IDLE_PCT;
		end
	end

	// watchdog on cycles with no beat moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (res_valid && !res_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout after %0d quiet cycles", quiet_cycles);
				$display("point_in_triangle_test: mismatch");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		longint ax, ay, bx, by, cx, cy, px, py, dx, dy, off;
		int     mode, lim, w1, w2, w3, k1, k2, k3;
		sent_cnt = 0;
		got_cnt = 0;
		err_cnt = 0;
		tri_cnt = 0;
		seg_cnt = 0;
		pt_cnt = 0;
		inside_cnt = 0;
		quiet_cycles = 0;

		// directed: single point
		pending_queries.push_back(mk_query(5, -7, 5, -7, 5, -7, 5, -7));
		pending_queries.push_back(mk_query(5, -7, 5, -7, 5, -7, 5, -6));
		pending_queries.push_back(mk_query(-32768, -32768, -32768, -32768, -32768, -32768,
			-32768, -32768));
		pending_queries.push_back(mk_query(32767, 32767, 32767, 32767, 32767, 32767,
			-32768, 32767));
		// directed: segments, including repeated vertices in each position
		pending_queries.push_back(mk_query(0, 0, 10, 20, 4, 8, 2, 4));
		pending_queries.push_back(mk_query(0, 0, 10, 20, 4, 8, 12, 24));
		pending_queries.push_back(mk_query(0, 0, 10, 20, 4, 8, 3, 4));
		pending_queries.push_back(mk_query(3, 3, 3, 3, -9, 6, -5, 5));
		pending_queries.push_back(mk_query(3, 3, 3, 3, -9, 6, -5, 6));
		pending_queries.push_back(mk_query(1, 2, 7, 5, 1, 2, 5, 4));
		pending_queries.push_back(mk_query(1, 2, 7, 5, 7, 5, 3, 3));
		pending_queries.push_back(mk_query(-32768, -32768, 32767, 32767, 0, 0, -1, -1));
		pending_queries.push_back(mk_query(-32768, 32767, 32767, -32768, 0, -1, 32767, -32768));
		// directed: proper triangles, both windings, edge, vertex, outside
		pending_queries.push_back(mk_query(0, 0, 10, 0, 0, 10, 2, 3));
		pending_queries.push_back(mk_query(0, 0, 0, 10, 10, 0, 2, 3));
		pending_queries.push_back(mk_query(0, 0, 10, 0, 0, 10, 5, 5));
		pending_queries.push_back(mk_query(0, 0, 10, 0, 0, 10, 10, 0));
		pending_queries.push_back(mk_query(0, 0, 10, 0, 0, 10, 6, 5));
		pending_queries.push_back(mk_query(-32768, -32768, 32767, -32768, -32768, 32767,
			32767, 32767));
		pending_queries.push_back(mk_query(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0));
		pending_queries.push_back(mk_query(-32768, 32767, 32767, -32768, -32768, -32768,
			-32768, -32768));
		pending_queries.push_back(mk_query(32767, 32767, -32768, 32767, 32767, -32768,
			-1, -1));

		// random: mostly shaped cases, the rest full-range noise
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			mode = $urandom_range(0, 99);
			if (mode < 60) begin
				case ($urandom_range(0, 2))
					0:       lim = 8;
					1:       lim = 256;
					default: lim = 32768;
				endcase
				off = (lim == 32768) ? 0 : pick_coord(32768 - lim);
				ax = pick_coord(lim) + off;
				ay = pick_coord(lim) + off;
				bx = pick_coord(lim) + off;
				by = pick_coord(lim) + off;
				cx = pick_coord(lim) + off;
				cy = pick_coord(lim) + off;
				if (mode < 45) begin
					// weighted blend of the vertices, mostly inside
					w1 = $urandom_range(0, 15);
					w2 = $urandom_range(0, 15);
					w3 = $urandom_range(0, 15);
					if (w1 + w2 + w3 == 0) w1 = 1;
					px = (w1 * ax + w2 * bx + w3 * cx) / (w1 + w2 + w3);
					py = (w1 * ay + w2 * by + w3 * cy) / (w1 + w2 + w3);
				end else begin
					// vertex, edge midpoint or bounding-box sample
					case ($urandom_range(0, 2))
						0: begin
							px = cx;
							py = cy;
						end
						1: begin
							px = (ax + bx) / 2;
							py = (ay + by) / 2;
						end
						default: begin
							px = $urandom_range(0, 1) ? min3(ax, bx, cx) : max3(ax, bx, cx);
							py = (ay + cy) / 2;
						end
					endcase
				end
			end else if (mode < 75) begin
				// collinear vertices along a short step
				ax = pick_coord(31000);
				ay = pick_coord(31000);
				dx = pick_coord(51);
				dy = pick_coord(51);
				k1 = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 40)) - 20;
				k2 = int'($urandom_range(0, 40)) - 20;
				k3 = int'($urandom_range(0, 50)) - 25;
				bx = ax + k1 * dx;
				by = ay + k1 * dy;
				cx = ax + k2 * dx;
				cy = ay + k2 * dy;
				px = ax + k3 * dx + (($urandom_range(0, 2) == 0) ? 1 : 0);
				py = ay + k3 * dy;
			end else if (mode < 82) begin
				// coincident vertices, point on or next to them
				ax = pick_coord(32767);
				ay = pick_coord(32767);
				bx = ax;
				by = ay;
				cx = ax;
				cy = ay;
				px = ax + (int'($urandom_range(0, 2)) - 1);
				py = ay + (int'($urandom_range(0, 2)) - 1);
			end else begin
				ax = pick_coord(32768);
				ay = pick_coord(32768);
				bx = pick_coord(32768);
				by = pick_coord(32768);
				cx = pick_coord(32768);
				cy = pick_coord(32768);
				px = pick_coord(32768);
				py = pick_coord(32768);
			end
			pending_queries.push_back(mk_query(ax, ay, bx, by, cx, cy, px, py));
		end

		// reset
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// wait for all beats to be taken and all results to arrive
		while (pending_queries.size() != 0 || item_valid) @(posedge clk);
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_verdicts.size() != 0) begin
			$error("%0d expectations left over", expected_verdicts.size());
			err_cnt++;
		end
		$display("checked %0d of %0d query beats: %0d triangle, %0d segment, %0d point cases",
			got_cnt, sent_cnt, tri_cnt, seg_cnt, pt_cnt);
		$display("%0d points found inside, %0d outside; %0d errors",
			inside_cnt, got_cnt - inside_cnt, err_cnt);
		if (err_cnt == 0) begin
			$display("point_in_triangle_test: match");
		end else begin
			$display("point_in_triangle_test: mismatch");
		end
		$finish;
	end

endmodule

FILE: sim.f
hdl/pit_pkg.sv
hdl/pit_cross.sv
hdl/point_in_triangle_test.sv
verif/tb.sv
